// ===== rtl/core/bvce_pkg.sv =====
// ----------------------------------------------------------------------------
// bvce_pkg
// Shared constants, register map and helper functions for the battery
// voltage and charge estimator.
// ----------------------------------------------------------------------------
package bvce_pkg;

   // register file geometry
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CHANNEL_W  = 8;
   localparam int RES_W      = 32;
   localparam int RSUM_W     = RES_W + 1;

   // result widths
   localparam int MV_W     = 16;
   localparam int CHARGE_W = 7;

   // highest usable adc input
   localparam logic [CHANNEL_W-1:0] MAX_CHANNEL = 8'd6;

   // register reset values
   localparam logic [RES_W-1:0] RES_RESET = 32'd100000;

   // register indexes (byte address bits [3:2])
   typedef enum logic [1:0] {
      REG_ADC_CHANNEL = 2'd0,
      REG_TOP_RES     = 2'd1,
      REG_BOTTOM_RES  = 2'd2
   } reg_index_type;

   // lithium-polymer curve breakpoints in mV
   localparam logic [MV_W-1:0] CURVE_FULL_MV = 16'd4200;
   localparam logic [MV_W-1:0] CURVE_HIGH_MV = 16'd3700;
   localparam logic [MV_W-1:0] CURVE_MID_MV  = 16'd3400;
   localparam logic [MV_W-1:0] CURVE_LOW_MV  = 16'd3200;

   // curve base percentages
   localparam logic [CHARGE_W-1:0] PCT_FULL = 7'd100;
   localparam logic [CHARGE_W-1:0] PCT_HIGH = 7'd50;
   localparam logic [CHARGE_W-1:0] PCT_MID  = 7'd5;

   // floor(n / 10) by reciprocal, exact for n below 1029
   function automatic logic [CHARGE_W-1:0] div10(input logic [9:0] n);
      logic [17:0] prod;
      prod = 18'(n) * 18'd205;
      return prod[17:11];
   endfunction

endpackage

// ===== rtl/core/bvce_div.sv =====
// ----------------------------------------------------------------------------
// bvce_div
// Bit-serial restoring divider: one quotient bit per cycle, shifted in
// at the bottom of the dividend register as the dividend shifts out.
// ----------------------------------------------------------------------------
module bvce_div #(
   parameter int DIVIDEND_W = 45,
   parameter int DIVISOR_W  = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;

   logic [DIVISOR_W:0]    rem_shift;
   logic [DIVISOR_W+1:0]  diff;

   // one trial subtraction per cycle
   always_comb begin
      rem_shift = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff      = {1'b0, rem_shift} - {2'b00, dsr_ff};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      dsr_in    = dsr_ff;
      quo_in    = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W);
         rem_in  = '0;
         dsr_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         if (diff[DIVISOR_W+1]) begin
            rem_in = rem_shift[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end else begin
            rem_in = diff[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath shift registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/bvce_mul.sv =====
// ----------------------------------------------------------------------------
// bvce_mul
// Bit-serial shift-and-add multiplier: the multiplier shifts out msb
// first, one partial product added per cycle.
// ----------------------------------------------------------------------------
module bvce_mul #(
   parameter int MPLIER_W = 12,
   parameter int MCAND_W  = 33
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [MPLIER_W-1:0]          mplier,
   input  logic [MCAND_W-1:0]           mcand,
   output logic                         done,
   output logic [MPLIER_W+MCAND_W-1:0]  product
);

   localparam int PROD_W = MPLIER_W + MCAND_W;
   localparam int CNT_W  = $clog2(MPLIER_W + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [MPLIER_W-1:0] mplier_ff, mplier_in;
   logic [MCAND_W-1:0]  mcand_ff, mcand_in;
   logic [PROD_W-1:0]   acc_ff, acc_in;

   // one partial product per cycle
   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      mplier_in = mplier_ff;
      mcand_in  = mcand_ff;
      acc_in    = acc_ff;
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = CNT_W'(MPLIER_W);
         mplier_in = mplier;
         mcand_in  = mcand;
         acc_in    = '0;
      end else if (busy_ff) begin
         acc_in    = {acc_ff[PROD_W-2:0], 1'b0}
                     + (mplier_ff[MPLIER_W-1] ? PROD_W'(mcand_ff) : '0);
         mplier_in = mplier_ff << 1;
         cnt_in    = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      mplier_ff <= mplier_in;
      mcand_ff  <= mcand_in;
      acc_ff    <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ===== rtl/core/bvce_curve.sv =====
// ----------------------------------------------------------------------------
// bvce_curve
// Piecewise-linear lithium-polymer discharge curve: battery mV to
// state of charge percent.
// ----------------------------------------------------------------------------
module bvce_curve (
   input  logic [bvce_pkg::MV_W-1:0]     mv,
   output logic [bvce_pkg::CHARGE_W-1:0] charge
);

   import bvce_pkg::*;

   logic [9:0] x_high;
   logic [9:0] x_mid;
   logic [9:0] x_mid3;
   logic [9:0] x_low;
   logic [CHARGE_W-1:0] q_mid;
   logic [CHARGE_W-1:0] q_low;

   // segment offsets, each narrow within its own segment
   always_comb begin
      x_high = 10'(mv - CURVE_HIGH_MV);
      x_mid  = 10'(mv - CURVE_MID_MV);
      x_mid3 = 10'(x_mid * 10'd3);
      x_low  = 10'(mv - CURVE_LOW_MV);
      q_mid  = div10(x_mid3) >> 1;
      q_low  = div10(x_low) >> 2;
   end

   // segment select
   always_comb begin
      if (mv >= CURVE_FULL_MV) begin
         charge = PCT_FULL;
      end else if (mv >= CURVE_HIGH_MV) begin
         charge = PCT_HIGH + div10(x_high);
      end else if (mv >= CURVE_MID_MV) begin
         charge = PCT_MID + q_mid;
      end else if (mv >= CURVE_LOW_MV) begin
         charge = q_low;
      end else begin
         charge = '0;
      end
   end

endmodule

// ===== rtl/core/battery_voltage_charge_estimator.sv =====
// ----------------------------------------------------------------------------
// battery_voltage_charge_estimator
// Averages groups of adc samples, scales the average through the resistor
// divider ratio and maps the battery voltage to a state of charge.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake         payload
//   req_      in         valid / ready     sample_mv
//   rsp_      out        valid / ready     battery_mv, charge_pct, status
//   csr_      in         apb, pready = 1   adc_channel, top/bottom resistance
//
// A sample that does not close a group is added to the running sum. The sample
// that closes a group starts a serial divide by the group size, a serial
// multiply by the resistor sum and a serial divide by the bottom resistance;
// a failed check skips the last two steps. Samples are held off during that
// time and while the result register is full at its end. Reset is
// synchronous and needs no clearing pass.
//
module battery_voltage_charge_estimator #(
   parameter int SAMPLES_PER_READING = 8,
   parameter int SAMPLE_BITS         = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   // sample input
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [SAMPLE_BITS-1:0]              req_sample_mv,
   // result output
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bvce_pkg::MV_W-1:0]           rsp_battery_mv,
   output logic [bvce_pkg::CHARGE_W-1:0]       rsp_charge_pct,
   output logic                                rsp_status,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bvce_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [bvce_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [bvce_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   import bvce_pkg::*;

   localparam int SUM_W  = SAMPLE_BITS + $clog2(SAMPLES_PER_READING);
   localparam int CNT_W  = $clog2(SAMPLES_PER_READING + 1);
   localparam int PROD_W = SAMPLE_BITS + RSUM_W;

   typedef enum logic [4:0] {
      ST_COLLECT = 5'b00001,
      ST_AVG     = 5'b00010,
      ST_MUL     = 5'b00100,
      ST_DIV     = 5'b01000,
      ST_PUBLISH = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CHANNEL_W-1:0]   channel_ff, channel_in;
   logic [RES_W-1:0]       top_ff, top_in;
   logic [RES_W-1:0]       bottom_ff, bottom_in;
   logic                   fail_ff, fail_in;
   logic [MV_W-1:0]        mv_ff, mv_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [MV_W-1:0]        rsp_mv_ff, rsp_mv_in;
   logic [CHARGE_W-1:0]    rsp_charge_ff, rsp_charge_in;
   logic                   rsp_status_ff, rsp_status_in;

   logic                   req_fire;
   logic                   csr_write;
   logic [SUM_W-1:0]       sum_next;
   logic                   group_last;
   logic [SAMPLE_BITS-1:0] avg;
   logic                   fail_now;
   logic [MV_W-1:0]        mv_sat;
   logic                   slot_free;

   logic                   div_start;
   logic [PROD_W-1:0]      div_dividend;
   logic [RES_W-1:0]       div_divisor;
   logic                   div_done;
   logic [PROD_W-1:0]      div_quo;

   logic                   mul_start;
   logic [RSUM_W-1:0]      rsum;
   logic                   mul_done;
   logic [PROD_W-1:0]      mul_product;

   logic [CHARGE_W-1:0]    charge;

   // handshake and shared terms
   assign req_ready  = (state_ff == ST_COLLECT);
   assign req_fire   = req_valid && req_ready;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign sum_next   = sum_ff + SUM_W'(req_sample_mv);
   assign group_last = (count_ff == CNT_W'(SAMPLES_PER_READING - 1));
   assign avg        = div_quo[SAMPLE_BITS-1:0];
   assign fail_now   = (channel_ff > MAX_CHANNEL) || (bottom_ff == '0) || (avg == '0);
   assign mv_sat     = (|div_quo[PROD_W-1:MV_W]) ? '1 : div_quo[MV_W-1:0];
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign rsum       = RSUM_W'(top_ff) + RSUM_W'(bottom_ff);

   // divider operand select: group size first, then bottom resistance
   always_comb begin
      if (state_ff == ST_COLLECT) begin
         div_dividend = PROD_W'(sum_next);
         div_divisor  = RES_W'(SAMPLES_PER_READING);
      end else begin
         div_dividend = mul_product;
         div_divisor  = bottom_ff;
      end
   end

   // register writes
   always_comb begin
      channel_in = channel_ff;
      top_in     = top_ff;
      bottom_in  = bottom_ff;
      if (csr_write) begin
         case (reg_index_type'(csr_paddr[3:2]))
            REG_ADC_CHANNEL: channel_in = csr_pwdata[CHANNEL_W-1:0];
            REG_TOP_RES:     top_in     = csr_pwdata[RES_W-1:0];
            REG_BOTTOM_RES:  bottom_in  = csr_pwdata[RES_W-1:0];
            default:         channel_in = channel_ff;
         endcase
      end
   end

   // register reads
   always_comb begin
      case (reg_index_type'(csr_paddr[3:2]))
         REG_ADC_CHANNEL: csr_prdata = CSR_DATA_W'(channel_ff);
         REG_TOP_RES:     csr_prdata = top_ff;
         REG_BOTTOM_RES:  csr_prdata = bottom_ff;
         default:         csr_prdata = '0;
      endcase
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      sum_in        = sum_ff;
      count_in      = count_ff;
      fail_in       = fail_ff;
      mv_in         = mv_ff;
      div_start     = 1'b0;
      mul_start     = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_mv_in     = rsp_mv_ff;
      rsp_charge_in = rsp_charge_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         ST_COLLECT: begin
            if (req_fire) begin
               if (group_last) begin
                  sum_in    = '0;
                  count_in  = '0;
                  div_start = 1'b1;
                  state_in  = ST_AVG;
               end else begin
                  sum_in   = sum_next;
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end
         ST_AVG: begin
            if (div_done) begin
               if (fail_now) begin
                  fail_in  = 1'b1;
                  mv_in    = '0;
                  state_in = ST_PUBLISH;
               end else begin
                  mul_start = 1'b1;
                  state_in  = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               fail_in  = 1'b0;
               mv_in    = mv_sat;
               state_in = ST_PUBLISH;
            end
         end
         ST_PUBLISH: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_mv_in     = mv_ff;
               rsp_charge_in = fail_ff ? '0 : charge;
               rsp_status_in = fail_ff;
               state_in      = ST_COLLECT;
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         sum_ff       <= '0;
         count_ff     <= '0;
         channel_ff   <= '0;
         top_ff       <= RES_RESET;
         bottom_ff    <= RES_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         channel_ff   <= channel_in;
         top_ff       <= top_in;
         bottom_ff    <= bottom_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      fail_ff       <= fail_in;
      mv_ff         <= mv_in;
      rsp_mv_ff     <= rsp_mv_in;
      rsp_charge_ff <= rsp_charge_in;
      rsp_status_ff <= rsp_status_in;
   end

   // shared serial divider
   bvce_div #(
      .DIVIDEND_W (PROD_W),
      .DIVISOR_W  (RES_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   // serial multiplier: average times resistor sum
   bvce_mul #(
      .MPLIER_W (SAMPLE_BITS),
      .MCAND_W  (RSUM_W)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mplier  (avg),
      .mcand   (rsum),
      .done    (mul_done),
      .product (mul_product)
   );

   // charge curve
   bvce_curve u_curve (
      .mv     (mv_ff),
      .charge (charge)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_battery_mv = rsp_mv_ff;
   assign rsp_charge_pct = rsp_charge_ff;
   assign rsp_status     = rsp_status_ff;

endmodule
